FILE: hdl/nmc_pkg.sv
// Shared types, codes and constants of the NVM mailbox controller.
package nmc_pkg;

  localparam int NVM_DWORDS_DEF = 65536;
  localparam int DATA_REG_COUNT = 16;
  localparam int DREG_AW        = 4;
  localparam int LEN_W          = 5;
  localparam int OFS_W          = 22;
  localparam int OFS_LSB        = 2;
  localparam int LEN_LSB        = 24;
  localparam int BIT_ERROR      = 30;
  localparam int BIT_VALID      = 31;

  localparam logic [4:0] IDX_METADATA = 5'd16;
  localparam logic [4:0] IDX_COMMAND  = 5'd17;

  localparam logic [15:0] OPC_WRITE      = 16'h0020;
  localparam logic [15:0] OPC_AUTH       = 16'h0021;
  localparam logic [15:0] OPC_READ       = 16'h0022;
  localparam logic [15:0] OPC_SET_OFFSET = 16'h0023;

  localparam logic [31:0] NVM_ERASED = 32'hffff_ffff;

  typedef struct packed {
    logic        operation;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        auth_pulse;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_COPY,
    ST_DRAIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               we;
    logic [DREG_AW-1:0] waddr;
    logic [31:0]        wdata;
    logic [DREG_AW-1:0] raddr;
  } dreg_req_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_stat_t;

endpackage

FILE: hdl/nmc_dreg.sv
// Data register file: sixteen dwords, one write and one registered read port.
module nmc_dreg (
  input  logic               clk,
  input  logic               rst_n,
  input  nmc_pkg::dreg_req_t req,
  output logic [31:0]        rdata
);

  logic [31:0]                      mem_r   [nmc_pkg::DATA_REG_COUNT];
  logic [nmc_pkg::DATA_REG_COUNT-1:0] valid_r;
  logic [31:0]                      rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rdata_r <= valid_r[req.raddr] ? mem_r[req.raddr] : '0;
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/nmc_nvm.sv
// NVM array: one write and one registered read port.
module nmc_nvm #(
  parameter int NVM_DWORDS = nmc_pkg::NVM_DWORDS_DEF,
  localparam int NVM_AW    = $clog2(NVM_DWORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [NVM_AW-1:0] waddr,
  input  logic [31:0]       wdata,
  input  logic [NVM_AW-1:0] raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem_r [NVM_DWORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/nmc_ctrl.sv
// Sequencer: register decode, command execution and the shared address adder.
module nmc_ctrl #(
  parameter int NVM_DWORDS = nmc_pkg::NVM_DWORDS_DEF,
  localparam int NVM_AW    = $clog2(NVM_DWORDS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  nmc_pkg::in_item_t   in_item,
  input  logic                res_take,
  output nmc_pkg::ctrl_stat_t stat,
  output nmc_pkg::out_item_t  res,
  output nmc_pkg::dreg_req_t  dreg_req,
  input  logic [31:0]         dreg_rdata,
  output logic                nvm_we,
  output logic [NVM_AW-1:0]   nvm_waddr,
  output logic [31:0]         nvm_wdata,
  output logic [NVM_AW-1:0]   nvm_raddr,
  input  logic [31:0]         nvm_rdata
);

  localparam int LIM_W = nmc_pkg::OFS_W + 1;
  localparam logic [LIM_W-1:0]  NVM_LIM   = LIM_W'(NVM_DWORDS);
  localparam logic [NVM_AW-1:0] CLR_LAST  = NVM_AW'(NVM_DWORDS - 1);
  localparam logic [nmc_pkg::LEN_W-1:0] FULL_LEN = nmc_pkg::LEN_W'(nmc_pkg::DATA_REG_COUNT);

  nmc_pkg::state_t    state_r, state_nxt;
  nmc_pkg::in_item_t  item_r, item_nxt;
  nmc_pkg::out_item_t res_r, res_nxt;
  logic [31:0]                  meta_r, meta_nxt;
  logic [31:0]                  cmd_r, cmd_nxt;
  logic [nmc_pkg::OFS_W-1:0]    woff_r, woff_nxt;
  logic [nmc_pkg::OFS_W-1:0]    base_r, base_nxt;
  logic [nmc_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [nmc_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                         dir_wr_r, dir_wr_nxt;
  logic                         pend_r, pend_nxt;
  logic [nmc_pkg::DREG_AW-1:0]  pidx_r, pidx_nxt;
  logic [NVM_AW-1:0]            paddr_r, paddr_nxt;
  logic [NVM_AW-1:0]            clr_r, clr_nxt;

  logic                         wr;
  logic [4:0]                   idx;
  logic [31:0]                  wd;
  logic [15:0]                  opc;
  logic                         run;
  logic                         is_dreg;
  logic [nmc_pkg::OFS_W-1:0]    meta_ofs;
  logic [nmc_pkg::LEN_W-1:0]    exec_len;
  logic [nmc_pkg::OFS_W-1:0]    add_a;
  logic [nmc_pkg::LEN_W-1:0]    add_b;
  logic [LIM_W-1:0]             sum;
  logic                         range_err;
  logic                         cmd_err;
  logic                         start_copy;

  assign wr       = item_r.operation;
  assign idx      = item_r.reg_index;
  assign wd       = item_r.write_data;
  assign opc      = wd[15:0];
  assign run      = wr && (idx == nmc_pkg::IDX_COMMAND) && wd[nmc_pkg::BIT_VALID];
  assign is_dreg  = (idx < 5'(nmc_pkg::DATA_REG_COUNT));
  assign meta_ofs = meta_r[nmc_pkg::OFS_LSB +: nmc_pkg::OFS_W];

  always_comb begin
    exec_len = FULL_LEN;
    if (opc == nmc_pkg::OPC_READ && meta_r[nmc_pkg::LEN_LSB +: 4] != 4'd0) begin
      exec_len = {1'b0, meta_r[nmc_pkg::LEN_LSB +: 4]};
    end
  end

  // shared adder: range check in decode, NVM address during copy, offset advance at end
  always_comb begin
    if (state_r == nmc_pkg::ST_EXEC) begin
      add_a = (opc == nmc_pkg::OPC_READ) ? meta_ofs : woff_r;
      add_b = exec_len;
    end else begin
      add_a = base_r;
      add_b = cnt_r;
    end
    sum = {1'b0, add_a} + LIM_W'(add_b);
  end

  assign range_err = (sum > NVM_LIM);

  always_comb begin
    case (opc) inside
      nmc_pkg::OPC_SET_OFFSET, nmc_pkg::OPC_AUTH: cmd_err = 1'b0;
      nmc_pkg::OPC_READ, nmc_pkg::OPC_WRITE:      cmd_err = range_err;
      default:                                    cmd_err = 1'b1;
    endcase
  end

  assign start_copy = run && !range_err &&
                      ((opc == nmc_pkg::OPC_READ) || (opc == nmc_pkg::OPC_WRITE));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nmc_pkg::ST_CLEAR:  if (clr_r == CLR_LAST) state_nxt = nmc_pkg::ST_IDLE;
      nmc_pkg::ST_IDLE:   if (in_valid) state_nxt = nmc_pkg::ST_EXEC;
      nmc_pkg::ST_EXEC: begin
        if (start_copy) begin
          state_nxt = nmc_pkg::ST_COPY;
        end else if (!wr && is_dreg) begin
          state_nxt = nmc_pkg::ST_RDWAIT;
        end else begin
          state_nxt = nmc_pkg::ST_RESP;
        end
      end
      nmc_pkg::ST_RDWAIT: state_nxt = nmc_pkg::ST_RESP;
      nmc_pkg::ST_COPY:   if (cnt_r == len_r - 1'b1) state_nxt = nmc_pkg::ST_DRAIN;
      nmc_pkg::ST_DRAIN:  state_nxt = nmc_pkg::ST_RESP;
      nmc_pkg::ST_RESP:   if (res_take) state_nxt = nmc_pkg::ST_IDLE;
      default:            state_nxt = nmc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt   = item_r;
    res_nxt    = res_r;
    meta_nxt   = meta_r;
    cmd_nxt    = cmd_r;
    woff_nxt   = woff_r;
    base_nxt   = base_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    dir_wr_nxt = dir_wr_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    paddr_nxt  = paddr_r;
    clr_nxt    = clr_r;

    dreg_req.we    = 1'b0;
    dreg_req.waddr = pidx_r;
    dreg_req.wdata = nvm_rdata;
    dreg_req.raddr = cnt_r[nmc_pkg::DREG_AW-1:0];
    nvm_we         = 1'b0;
    nvm_waddr      = paddr_r;
    nvm_wdata      = dreg_rdata;
    nvm_raddr      = sum[NVM_AW-1:0];

    // retire the copy beat issued last cycle
    if (pend_r) begin
      if (dir_wr_r) begin
        nvm_we = 1'b1;
      end else begin
        dreg_req.we = 1'b1;
      end
    end

    unique case (state_r)
      nmc_pkg::ST_CLEAR: begin
        nvm_we    = 1'b1;
        nvm_waddr = clr_r;
        nvm_wdata = nmc_pkg::NVM_ERASED;
        clr_nxt   = clr_r + 1'b1;
      end
      nmc_pkg::ST_IDLE: begin
        if (in_valid) item_nxt = in_item;
      end
      nmc_pkg::ST_EXEC: begin
        dreg_req.raddr     = idx[nmc_pkg::DREG_AW-1:0];
        res_nxt.read_data  = '0;
        res_nxt.auth_pulse = run && (opc == nmc_pkg::OPC_AUTH);
        if (!wr) begin
          if (idx == nmc_pkg::IDX_METADATA) res_nxt.read_data = meta_r;
          if (idx == nmc_pkg::IDX_COMMAND)  res_nxt.read_data = cmd_r;
        end else if (is_dreg) begin
          dreg_req.we    = 1'b1;
          dreg_req.waddr = idx[nmc_pkg::DREG_AW-1:0];
          dreg_req.wdata = wd;
        end else if (idx == nmc_pkg::IDX_METADATA) begin
          meta_nxt = wd;
        end else if (idx == nmc_pkg::IDX_COMMAND) begin
          cmd_nxt = wd[nmc_pkg::BIT_VALID] ? {1'b0, cmd_err, wd[29:0]} : wd;
        end
        if (run && opc == nmc_pkg::OPC_SET_OFFSET) woff_nxt = meta_ofs;
        base_nxt   = add_a;
        len_nxt    = exec_len;
        cnt_nxt    = '0;
        dir_wr_nxt = (opc == nmc_pkg::OPC_WRITE);
      end
      nmc_pkg::ST_RDWAIT: begin
        res_nxt.read_data = dreg_rdata;
      end
      nmc_pkg::ST_COPY: begin
        pend_nxt  = 1'b1;
        pidx_nxt  = cnt_r[nmc_pkg::DREG_AW-1:0];
        paddr_nxt = sum[NVM_AW-1:0];
        cnt_nxt   = cnt_r + 1'b1;
      end
      nmc_pkg::ST_DRAIN: begin
        if (dir_wr_r) woff_nxt = sum[nmc_pkg::OFS_W-1:0];
      end
      nmc_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nmc_pkg::ST_CLEAR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      meta_r  <= '0;
      cmd_r   <= '0;
      woff_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      meta_r  <= meta_nxt;
      cmd_r   <= cmd_nxt;
      woff_r  <= woff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    res_r    <= res_nxt;
    base_r   <= base_nxt;
    len_r    <= len_nxt;
    cnt_r    <= cnt_nxt;
    dir_wr_r <= dir_wr_nxt;
    pidx_r   <= pidx_nxt;
    paddr_r  <= paddr_nxt;
  end

  assign stat.busy      = (state_r != nmc_pkg::ST_IDLE);
  assign stat.res_valid = (state_r == nmc_pkg::ST_RESP);
  assign res            = res_r;

endmodule

FILE: hdl/nvm_mailbox_controller_top.sv
// Top level of the NVM mailbox controller: sequencer, stores and result register.
//
//  channel  dir  handshake            beat
//  in       in   in_valid / in_stall  in_item  (operation, reg_index, write_data)
//  out      out  out_valid / out_stall out_item (read_data, auth_pulse)
//
// A plain register access passes from IDLE through EXEC to RESP; a data register read adds RDWAIT.
// NVM read and NVM write pass through EXEC, COPY and DRAIN to RESP, moving one dword per
// cycle through the shared address adder and the NVM read and write ports.
// After reset the NVM is swept to all ones with in_stall high.
// The result register holds a beat under out_stall; the next item is taken meanwhile.
module nvm_mailbox_controller_top #(
  parameter int NVM_DWORDS = nmc_pkg::NVM_DWORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nmc_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output nmc_pkg::out_item_t out_item
);

  localparam int NVM_AW = $clog2(NVM_DWORDS);

  nmc_pkg::ctrl_stat_t stat;
  nmc_pkg::out_item_t  res;
  nmc_pkg::dreg_req_t  dreg_req;
  logic [31:0]         dreg_rdata;
  logic                nvm_we;
  logic [NVM_AW-1:0]   nvm_waddr;
  logic [31:0]         nvm_wdata;
  logic [NVM_AW-1:0]   nvm_raddr;
  logic [31:0]         nvm_rdata;
  logic                res_take;

  logic               out_valid_r, out_valid_nxt;
  nmc_pkg::out_item_t out_item_r, out_item_nxt;

  nmc_ctrl #(.NVM_DWORDS(NVM_DWORDS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .res_take   (res_take),
    .stat       (stat),
    .res        (res),
    .dreg_req   (dreg_req),
    .dreg_rdata (dreg_rdata),
    .nvm_we     (nvm_we),
    .nvm_waddr  (nvm_waddr),
    .nvm_wdata  (nvm_wdata),
    .nvm_raddr  (nvm_raddr),
    .nvm_rdata  (nvm_rdata)
  );

  nmc_dreg u_dreg (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreg_req),
    .rdata (dreg_rdata)
  );

  nmc_nvm #(.NVM_DWORDS(NVM_DWORDS)) u_nvm (
    .clk   (clk),
    .we    (nvm_we),
    .waddr (nvm_waddr),
    .wdata (nvm_wdata),
    .raddr (nvm_raddr),
    .rdata (nvm_rdata)
  );

  assign res_take = stat.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = stat.busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while previous item still in progress");

  a_auth_on_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.auth_pulse && (out_item.read_data != 32'd0)))
    else $error("auth pulse together with nonzero read data");

  a_take_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && (out_item == $past(res))))
    else $error("result not loaded into output register");

endmodule

FILE: test/testbench.sv
// Testbench for the NVM mailbox controller: register traffic and commands checked beat by beat.
`timescale 1ns / 1ps

module testbench;

  localparam int NVM_WORDS = nmc_pkg::NVM_DWORDS_DEF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [4:0] IDX_DATA_FIRST  = 5'd0;
  localparam logic [4:0] IDX_DATA_LAST   = 5'd15;
  localparam logic [4:0] IDX_UNMAPPED_LO = 5'd18;
  localparam logic [4:0] IDX_UNMAPPED_HI = 5'd31;

  localparam logic [15:0] OPC_DROM    = 16'h0024;
  localparam logic [15:0] OPC_ALIASED = 16'h1020;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  nmc_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  nmc_pkg::out_item_t out_item;

  nvm_mailbox_controller_top #(.NVM_DWORDS(NVM_WORDS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // mailbox image
  logic [31:0] data_img [nmc_pkg::DATA_REG_COUNT];
  logic [31:0] meta_img;
  logic [31:0] cmd_img;
  logic [21:0] wofs_img;
  logic [31:0] nvm_img [NVM_WORDS];

  nmc_pkg::out_item_t access_results [$];
  int        idle_rate   = 0;
  int        stall_left  = 0;
  int        beats_sent  = 0;
  int        results_seen = 0;
  int        mismatches  = 0;
  int        nvm_writes  = 0;
  int        nvm_reads   = 0;
  int        auths       = 0;
  int        cmd_errors  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd10_000_000);
    $display("nvm_mailbox_controller_top: mismatch");
    $finish;
  end

  function automatic nmc_pkg::out_item_t mailbox_access(input nmc_pkg::in_item_t it);
    nmc_pkg::out_item_t r;
    logic        err;
    logic [21:0] ofs;
    int unsigned len;
    int          i;
    r = '0;
    if (it.operation == OP_READ) begin
      if (it.reg_index < nmc_pkg::DATA_REG_COUNT) r.read_data = data_img[it.reg_index[3:0]];
      else if (it.reg_index == nmc_pkg::IDX_METADATA) r.read_data = meta_img;
      else if (it.reg_index == nmc_pkg::IDX_COMMAND) r.read_data = cmd_img;
    end else if (it.reg_index < nmc_pkg::DATA_REG_COUNT) begin
      data_img[it.reg_index[3:0]] = it.write_data;
    end else if (it.reg_index == nmc_pkg::IDX_METADATA) begin
      meta_img = it.write_data;
    end else if (it.reg_index == nmc_pkg::IDX_COMMAND) begin
      cmd_img = it.write_data;
      if (it.write_data[nmc_pkg::BIT_VALID]) begin
        err = 1'b0;
        case (it.write_data[15:0])
          nmc_pkg::OPC_SET_OFFSET: wofs_img = meta_img[23:2];
          nmc_pkg::OPC_READ: begin
            ofs = meta_img[23:2];
            len = meta_img[27:24];
            if (len == 0) len = nmc_pkg::DATA_REG_COUNT;
            if (longint'(ofs) + len > NVM_WORDS) err = 1'b1;
            else begin
              for (i = 0; i < len; i++) data_img[i] = nvm_img[ofs + i];
              nvm_reads++;
            end
          end
          nmc_pkg::OPC_WRITE: begin
            if (longint'(wofs_img) + nmc_pkg::DATA_REG_COUNT > NVM_WORDS) err = 1'b1;
            else begin
              for (i = 0; i < nmc_pkg::DATA_REG_COUNT; i++) nvm_img[wofs_img + i] = data_img[i];
              wofs_img = wofs_img + 22'(nmc_pkg::DATA_REG_COUNT);
              nvm_writes++;
            end
          end
          nmc_pkg::OPC_AUTH: begin
            r.auth_pulse = 1'b1;
            auths++;
          end
          default: err = 1'b1;
        endcase
        cmd_img[nmc_pkg::BIT_VALID] = 1'b0;
        cmd_img[nmc_pkg::BIT_ERROR] = err;
        if (err) cmd_errors++;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    nmc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (access_results.size() == 0) begin
        note_mismatch("beat with nothing pending, read_data", 32'h0, out_item.read_data);
      end else begin
        want = access_results.pop_front();
        if (out_item.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, out_item.read_data);
        if (out_item.auth_pulse !== want.auth_pulse)
          note_mismatch("auth_pulse", 32'(want.auth_pulse), 32'(out_item.auth_pulse));
      end
    end
  end

  always @(posedge clk) begin
    if (idle_rate == 0) out_stall <= 1'b0;
    else if (stall_left != 0) stall_left <= stall_left - 1;
    else if (out_stall) out_stall <= 1'b0;
    else if ($urandom_range(0, 7) < idle_rate) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end
  end

  task automatic send_beat(input nmc_pkg::in_item_t it);
    if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    access_results.push_back(mailbox_access(it));
    beats_sent++;
  endtask

  task automatic reg_write(input logic [4:0] idx, input logic [31:0] d);
    nmc_pkg::in_item_t it;
    it.operation  = OP_WRITE;
    it.reg_index  = idx;
    it.write_data = d;
    send_beat(it);
  endtask

  task automatic reg_read(input logic [4:0] idx);
    nmc_pkg::in_item_t it;
    it.operation  = OP_READ;
    it.reg_index  = idx;
    it.write_data = $urandom();
    send_beat(it);
  endtask

  task automatic run_command(input logic [15:0] opc);
    reg_write(nmc_pkg::IDX_COMMAND, {1'b1, 1'($urandom), 14'($urandom), opc});
  endtask

  function automatic logic [31:0] meta_word(input logic [21:0] ofs, input logic [3:0] len);
    return {4'($urandom), len, ofs, 2'($urandom)};
  endfunction

  function automatic logic [21:0] pick_offset();
    case ($urandom_range(0, 9))
      0, 1:    return 22'($urandom);
      2, 3:    return 22'(NVM_WORDS - $urandom_range(1, 40));
      default: return 22'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (access_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_register_file();
    reg_write(IDX_DATA_FIRST, 32'hffff_ffff);
    reg_write(IDX_DATA_LAST, 32'h0000_0000);
    reg_read(IDX_DATA_FIRST);
    reg_read(IDX_DATA_LAST);
    reg_write(nmc_pkg::IDX_METADATA, 32'hffff_ffff);
    reg_read(nmc_pkg::IDX_METADATA);
    reg_write(nmc_pkg::IDX_COMMAND, {2'b01, 14'h3fff, nmc_pkg::OPC_AUTH});
    reg_read(nmc_pkg::IDX_COMMAND);
    reg_write(IDX_UNMAPPED_LO, 32'h1234_5678);
    reg_read(IDX_UNMAPPED_LO);
    reg_read(IDX_UNMAPPED_HI);
  endtask

  task automatic test_nvm_commands();
    reg_write(nmc_pkg::IDX_METADATA, meta_word(22'd0, 4'd0));
    run_command(nmc_pkg::OPC_READ);
    reg_read(IDX_DATA_LAST);
    reg_write(IDX_DATA_FIRST, 32'h0000_0000);
    run_command(nmc_pkg::OPC_WRITE);
    run_command(nmc_pkg::OPC_READ);
    reg_read(IDX_DATA_FIRST);
    run_command(nmc_pkg::OPC_AUTH);
    run_command(OPC_DROM);
    run_command(OPC_ALIASED);
    reg_read(nmc_pkg::IDX_COMMAND);
    reg_write(nmc_pkg::IDX_METADATA, meta_word(22'(NVM_WORDS - 8), 4'd0));
    run_command(nmc_pkg::OPC_READ);
    run_command(nmc_pkg::OPC_SET_OFFSET);
    run_command(nmc_pkg::OPC_WRITE);
    reg_write(nmc_pkg::IDX_METADATA, meta_word(22'(NVM_WORDS - 16), 4'd15));
    run_command(nmc_pkg::OPC_READ);
    run_command(nmc_pkg::OPC_SET_OFFSET);
    run_command(nmc_pkg::OPC_WRITE);
    run_command(nmc_pkg::OPC_WRITE);
    reg_read(nmc_pkg::IDX_COMMAND);
  endtask

  task automatic test_random_traffic(input int n_items, input bit quiet);
    int                stop_at;
    int                k;
    nmc_pkg::in_item_t it;
    stop_at = beats_sent + n_items;
    while (beats_sent < stop_at) begin
      idle_rate = quiet ? 0 : $urandom_range(0, 3);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          if ($urandom_range(0, 1) == 0) begin
            reg_write(nmc_pkg::IDX_METADATA, meta_word(pick_offset(), 4'($urandom)));
            run_command(nmc_pkg::OPC_SET_OFFSET);
          end
          k = $urandom_range(0, 16);
          repeat (k) reg_write(5'($urandom_range(0, 15)), $urandom());
          run_command(nmc_pkg::OPC_WRITE);
        end
        7, 8, 9, 10, 11: begin
          reg_write(nmc_pkg::IDX_METADATA, meta_word(pick_offset(), 4'($urandom)));
          run_command(nmc_pkg::OPC_READ);
          repeat ($urandom_range(1, 4)) reg_read(5'($urandom_range(0, 15)));
          reg_read(nmc_pkg::IDX_COMMAND);
        end
        12, 13: begin
          reg_write(nmc_pkg::IDX_METADATA, meta_word(pick_offset(), 4'($urandom)));
          run_command(nmc_pkg::OPC_SET_OFFSET);
          reg_read(nmc_pkg::IDX_METADATA);
        end
        14: begin
          case ($urandom_range(0, 3))
            0: run_command(nmc_pkg::OPC_AUTH);
            1: run_command(OPC_DROM);
            2: run_command(16'($urandom));
            default: reg_write(nmc_pkg::IDX_COMMAND, {1'b0, 31'($urandom)});
          endcase
          reg_read(nmc_pkg::IDX_COMMAND);
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            it = nmc_pkg::in_item_t'({1'($urandom), 5'($urandom), 32'($urandom)});
            send_beat(it);
          end
        end
      endcase
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NVM_WORDS; i++) nvm_img[i] = nmc_pkg::NVM_ERASED;
    for (i = 0; i < nmc_pkg::DATA_REG_COUNT; i++) data_img[i] = '0;
    meta_img = '0;
    cmd_img  = '0;
    wofs_img = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_register_file();
    test_nvm_commands();
    test_random_traffic(1200, 1'b0);
    wait_results_drained();
    test_random_traffic(500, 1'b0);
    test_random_traffic(300, 1'b1);
    wait_results_drained();
    repeat (40) @(posedge clk);

    $display("Sent %0d beats, checked %0d results.", beats_sent, results_seen);
    $display("Commands run: %0d NVM writes, %0d NVM reads, %0d authenticates, %0d errors.",
             nvm_writes, nvm_reads, auths, cmd_errors);
    if (mismatches == 0) begin
      $display("nvm_mailbox_controller_top: match");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("nvm_mailbox_controller_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: nvm_mailbox_controller_top.f
hdl/nmc_pkg.sv
hdl/nmc_dreg.sv
hdl/nmc_nvm.sv
hdl/nmc_ctrl.sv
hdl/nvm_mailbox_controller_top.sv
test/testbench.sv
